[src/packet_header_payload_crc_checker_top_assert.svh]
// Assertion macros for the packet header and payload CRC checker
`ifndef PACKET_HEADER_PAYLOAD_CRC_CHECKER_TOP_ASSERT_SVH
`define PACKET_HEADER_PAYLOAD_CRC_CHECKER_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define PHCC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("phcc assertion failed");

// next-cycle implication, off during reset
`define PHCC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("phcc assertion failed");

`endif

[src/phcc_pkg.sv]
// Shared types, codes and the CRC byte update for the packet CRC checker
`default_nettype none

package phcc_pkg;

  localparam logic [15:0] CRC_POLY = 16'h8408;

  localparam logic [1:0] STATUS_GOOD    = 2'd0;
  localparam logic [1:0] STATUS_HDR_ERR = 2'd1;
  localparam logic [1:0] STATUS_PAY_ERR = 2'd2;

  localparam logic [2:0] IDX_FIRST    = 3'd0;
  localparam logic [2:0] IDX_KIND     = 3'd2;
  localparam logic [2:0] IDX_OPT      = 3'd3;
  localparam logic [2:0] HDR_LAST_IDX = 3'd5;

  localparam logic [8:0] CRC_BYTES = 9'd2;
  localparam int unsigned KIND_PAYLOAD_BIT = 7;

  typedef enum logic [1:0] {
    OP_HDR      = 2'd0,
    OP_PAY      = 2'd1,
    OP_PAY_LAST = 2'd2
  } beat_op_e;

  typedef struct packed {
    logic [7:0] data;
    beat_op_e   op;
    logic [2:0] idx;
  } beat_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] receiver_addr;
    logic [7:0] sender_addr;
    logic [7:0] packet_kind;
    logic [7:0] option_or_length;
    logic       has_payload;
  } result_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[src/phcc_fifo.sv]
// Small register queue used between the front, the back and the result port
`default_nettype none

module phcc_fifo #(
  parameter int unsigned Depth = 4,
  parameter int unsigned Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      data_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

[src/phcc_front.sv]
// Front end: tracks packet framing and tags each byte as a header or payload beat
`default_nettype none

module phcc_front (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       packet_start_i,
  output logic            beat_valid_o,
  output phcc_pkg::beat_t beat_o
);

  import phcc_pkg::*;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_HEADER  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;

  logic [1:0] phase_q, phase_d;
  logic [8:0] cnt_q, cnt_d;
  logic [8:0] cnt_inc;
  logic [8:0] pay_end;
  logic       kind_flag_q, kind_flag_d;
  logic [7:0] len_q, len_d;

  assign cnt_inc = cnt_q + 9'd1;
  assign pay_end = {1'b0, len_q} + CRC_BYTES;

  always_comb begin
    phase_d      = phase_q;
    cnt_d        = cnt_q;
    kind_flag_d  = kind_flag_q;
    len_d        = len_q;
    beat_valid_o = 1'b0;
    beat_o.data  = data_byte_i;
    beat_o.op    = OP_HDR;
    beat_o.idx   = cnt_q[2:0];
    if (accept_i) begin
      if (packet_start_i) begin
        beat_valid_o = 1'b1;
        beat_o.idx   = IDX_FIRST;
        phase_d      = PH_HEADER;
        cnt_d        = 9'd1;
      end else begin
        case (phase_q)
          PH_HEADER: begin
            beat_valid_o = 1'b1;
            if (cnt_q[2:0] == IDX_KIND) begin
              kind_flag_d = data_byte_i[KIND_PAYLOAD_BIT];
            end
            if (cnt_q[2:0] == IDX_OPT) begin
              len_d = data_byte_i;
            end
            if (cnt_q[2:0] == HDR_LAST_IDX) begin
              phase_d = kind_flag_q ? PH_PAYLOAD : PH_IDLE;
              cnt_d   = '0;
            end else begin
              cnt_d = cnt_inc;
            end
          end
          PH_PAYLOAD: begin
            beat_valid_o = 1'b1;
            if (cnt_inc >= pay_end) begin
              beat_o.op = OP_PAY_LAST;
              phase_d   = PH_IDLE;
              cnt_d     = '0;
            end else begin
              beat_o.op = OP_PAY;
              cnt_d     = cnt_inc;
            end
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_flag_q <= kind_flag_d;
    len_q       <= len_d;
  end

endmodule

`default_nettype wire

[src/phcc_back.sv]
// Back end: runs the CRC over queued beats, keeps the header and builds results
`default_nettype none

module phcc_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             beat_valid_i,
  input  wire phcc_pkg::beat_t  beat_i,
  output logic                  beat_pop_o,
  input  wire logic             res_full_i,
  output logic                  res_push_o,
  output phcc_pkg::result_t     result_o
);

  import phcc_pkg::*;

  logic [7:0]  hdr_q [4];
  logic [15:0] crc_q, crc_d;
  logic [15:0] crc_in, crc_next;
  logic        pay_ok_q, pay_ok_d;
  logic        take;

  assign take       = beat_valid_i && !res_full_i;
  assign beat_pop_o = take;

  assign crc_in   = (beat_i.op == OP_HDR && beat_i.idx == IDX_FIRST) ? 16'h0000 : crc_q;
  assign crc_next = crc_byte(crc_in, beat_i.data);

  always_comb begin
    crc_d                    = crc_q;
    pay_ok_d                 = pay_ok_q;
    res_push_o               = 1'b0;
    result_o.status          = STATUS_GOOD;
    result_o.receiver_addr   = hdr_q[0];
    result_o.sender_addr     = hdr_q[1];
    result_o.packet_kind     = hdr_q[2];
    result_o.option_or_length = hdr_q[3];
    result_o.has_payload     = 1'b0;
    if (take) begin
      case (beat_i.op)
        OP_HDR: begin
          crc_d = crc_next;
          if (beat_i.idx == IDX_FIRST) begin
            pay_ok_d = 1'b0;
          end
          if (beat_i.idx == HDR_LAST_IDX) begin
            if (crc_next != 16'h0000) begin
              res_push_o      = 1'b1;
              result_o.status = STATUS_HDR_ERR;
            end else if (!hdr_q[2][KIND_PAYLOAD_BIT]) begin
              res_push_o = 1'b1;
            end else begin
              pay_ok_d = 1'b1;
              crc_d    = 16'h0000;
            end
          end
        end
        OP_PAY: begin
          if (pay_ok_q) begin
            crc_d = crc_next;
          end
        end
        OP_PAY_LAST: begin
          if (pay_ok_q) begin
            crc_d                = crc_next;
            pay_ok_d             = 1'b0;
            res_push_o           = 1'b1;
            result_o.has_payload = 1'b1;
            result_o.status      = (crc_next == 16'h0000) ? STATUS_GOOD : STATUS_PAY_ERR;
          end
        end
        default: begin
          pay_ok_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q    <= '0;
      pay_ok_q <= 1'b0;
    end else begin
      crc_q    <= crc_d;
      pay_ok_q <= pay_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && beat_i.op == OP_HDR && !beat_i.idx[2]) begin
      hdr_q[beat_i.idx[1:0]] <= beat_i.data;
    end
  end

endmodule

`default_nettype wire

[src/packet_header_payload_crc_checker_top.sv]
// Packet header and payload CRC checker, top level
//
// Input channel: one packet byte per beat on data_byte_i, taken when push_i is
// high and full_o is low. packet_start_i marks the first header byte and drops
// any partial packet. Bytes outside a packet without packet_start_i are ignored.
// Result channel: one status beat per packet, shown while empty_o is low and
// taken when pop_i is high; status_o is good, header CRC error or payload CRC
// error, with the four header bytes and has_payload_o alongside.
// Throughput: one byte per cycle while full_o is low, set by the byte-wide CRC
// update in the back end. The front end tags each byte straight into the beat
// queue; the back end takes the last beat from it and writes the result into
// the result queue, whose registered count then clears empty_o.
// The front end classifies bytes into a BeatDepth-entry queue; the back end
// drains it into a ResultDepth-entry result queue. A stalled receiver fills the
// result queue, then the beat queue, then raises full_o.
// Reset empties both queues and returns framing to idle awaiting a start byte.
`default_nettype none

module packet_header_payload_crc_checker_top #(
  parameter int unsigned BeatDepth   = 4,
  parameter int unsigned ResultDepth = 2
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  output logic            full_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       packet_start_i,
  input  wire logic       pop_i,
  output logic            empty_o,
  output logic [1:0]      status_o,
  output logic [7:0]      receiver_addr_o,
  output logic [7:0]      sender_addr_o,
  output logic [7:0]      packet_kind_o,
  output logic [7:0]      option_or_length_o,
  output logic            has_payload_o
);

  import phcc_pkg::*;

  localparam int unsigned BeatW = $bits(beat_t);
  localparam int unsigned ResW  = $bits(result_t);

  logic    accept;
  logic    beat_valid;
  beat_t   beat_in, beat_out;
  logic    beat_empty, beat_pop;
  logic    res_full, res_push;
  result_t res_in, res_out;

  assign accept = push_i && !full_o;

  phcc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .data_byte_i    (data_byte_i),
    .packet_start_i (packet_start_i),
    .beat_valid_o   (beat_valid),
    .beat_o         (beat_in)
  );

  phcc_fifo #(
    .Depth (BeatDepth),
    .Width (BeatW)
  ) u_beat_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (beat_valid),
    .data_i  (beat_in),
    .full_o  (full_o),
    .pop_i   (beat_pop),
    .data_o  (beat_out),
    .empty_o (beat_empty)
  );

  phcc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_valid_i (!beat_empty),
    .beat_i       (beat_out),
    .beat_pop_o   (beat_pop),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .result_o     (res_in)
  );

  phcc_fifo #(
    .Depth (ResultDepth),
    .Width (ResW)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop_i),
    .data_o  (res_out),
    .empty_o (empty_o)
  );

  assign status_o           = res_out.status;
  assign receiver_addr_o    = res_out.receiver_addr;
  assign sender_addr_o      = res_out.sender_addr;
  assign packet_kind_o      = res_out.packet_kind;
  assign option_or_length_o = res_out.option_or_length;
  assign has_payload_o      = res_out.has_payload;

endmodule

`default_nettype wire

[src/phcc_checker.sv]
// Port-level assertions for the packet CRC checker and their bind
`default_nettype none

`include "packet_header_payload_crc_checker_top_assert.svh"

module phcc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       pop_i,
  input wire logic       empty_o,
  input wire logic [1:0] status_o,
  input wire logic [7:0] packet_kind_o,
  input wire logic       has_payload_o
);

  import phcc_pkg::*;

  `PHCC_ASSERT_NOW(a_status_code, clk_i, rst_ni, !empty_o, status_o != 2'd3)
  `PHCC_ASSERT_NOW(a_hdr_err_no_pay, clk_i, rst_ni, !empty_o && status_o == STATUS_HDR_ERR, !has_payload_o)
  `PHCC_ASSERT_NOW(a_pay_err_has_pay, clk_i, rst_ni, !empty_o && status_o == STATUS_PAY_ERR, has_payload_o)
  `PHCC_ASSERT_NOW(a_pay_needs_flag, clk_i, rst_ni, !empty_o && has_payload_o, packet_kind_o[KIND_PAYLOAD_BIT])
  `PHCC_ASSERT_NEXT(a_result_holds, clk_i, rst_ni, !empty_o && !pop_i, !empty_o && $stable(status_o))

endmodule

bind packet_header_payload_crc_checker_top phcc_checker u_phcc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .pop_i         (pop_i),
  .empty_o       (empty_o),
  .status_o      (status_o),
  .packet_kind_o (packet_kind_o),
  .has_payload_o (has_payload_o)
);

`default_nettype wire
